@@ src/rrta_pkg.sv @@
`default_nettype none
package rrta_pkg;
    typedef enum logic [2:0] {
        CMD_ADD   = 3'd0,
        CMD_SETLEN = 3'd1,
        CMD_DONE  = 3'd2,
        CMD_LOWEST = 3'd3,
        CMD_AUDIT = 3'd4,
        CMD_CLEAR = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NEW     = 3'd0,
        ST_FOUND   = 3'd1,
        ST_NONE    = 3'd2,
        ST_FULL    = 3'd3,
        ST_RECORD  = 3'd4,
        ST_SUMMARY = 3'd5
    } t_status;

    localparam int CFG_NEWER   = 0;
    localparam int CFG_SECTION = 1;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] key_out;
        logic [32:0] region_end;
        logic [32:0] prior_end;
        logic        many_primary;
        logic        mixed_refs;
        logic        overlaps;
        logic        past_section;
        logic [32:0] inner_gap;
        logic [33:0] unused_total;
        logic [5:0]  entry_total;
        logic        last;
    } t_result;
endpackage
`default_nettype wire

@@ src/rrta_out_reg.sv @@
`default_nettype none
module rrta_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  rrta_pkg::t_result    i_data,
    output logic                 o_valid,
    input  wire                  i_ready,
    output rrta_pkg::t_result    o_data
);
    import rrta_pkg::*;

    logic     r_valid;
    t_result  r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end
endmodule
`default_nettype wire

@@ src/region_refcount_table_audit_top.sv @@
// Region reference-count table with audit.
// Slave channel: s_axis_* carries one request (command, offset, length,
// primary_ref). Master channel: m_axis_* carries result records; tlast marks
// the final result of a request. Configuration is a plain write port
// (index 0 newer_format, index 1 section_bytes), to be written by the user
// only while idle; the block itself does not enforce this. Entries live in a
// synchronous memory with a registered read port; a valid bit per slot sits
// in flip-flops, cleared by reset and by clear. Add, set length, mark done
// and lowest undone: the request is taken in idle, then one memory read
// pass over all slots and a write-back state that waits for the output
// register; the next request is taken only after the write-back.
// Audit: one pass over all slots per entry to find the next key in order,
// then an emit state per record, then a last empty pass and the summary.
// Clear: all valid bits drop and a single result is returned.
// One request is in work at a time. Results go through an output register,
// so a stalled receiver holds the walk until the record is taken.
// After reset the table is empty and both registers are zero.
`default_nettype none
module region_refcount_table_audit_top #(
    parameter int TABLE_ENTRIES = 32,
    parameter int COUNT_BITS    = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: command[2:0], offset[34:3], length[66:35], primary_ref[67], pad
    input  wire [71:0]  s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tdata: status[2:0], key_out[34:3], region_end[67:35], prior_end[100:68],
    // many_primary[101], mixed_refs[102], overlaps[103], past_section[104],
    // inner_gap[137:105], unused_total[171:138], entry_total[177:172], pad
    output logic [183:0] m_axis_tdata,
    output logic        m_axis_tlast,
    input  wire         i_cfg_we,
    input  wire [0:0]   i_cfg_index,
    input  wire [31:0]  i_cfg_data
);
    import rrta_pkg::*;

    localparam int IW = $clog2(TABLE_ENTRIES);
    localparam int EW = IW + 1;
    localparam int MW = 32 + 32 + 2 * COUNT_BITS + 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_WRITE, S_EMIT, S_SUMMARY
    } t_state;

    t_state r_state;
    logic r_newer;
    logic [31:0] r_section;

    // entry memory: {key, length, primary, secondary, done}
    logic [MW-1:0] mem [TABLE_ENTRIES];
    logic [MW-1:0] r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_wa;
    logic [MW-1:0] mem_wd;
    logic [IW-1:0] rd_addr;

    logic [TABLE_ENTRIES-1:0] r_valid, r_seen;

    logic [2:0]  r_cmd;
    logic [31:0] r_off, r_len;
    logic        r_prim;

    logic [EW-1:0] r_idx;
    logic          r_rd_ok;
    logic [IW-1:0] r_rd_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [MW-1:0] r_hit_data;
    logic          r_best_ok;
    logic [IW-1:0] r_best_idx;
    logic [MW-1:0] r_best_data;

    logic          r_first;
    logic [31:0]   r_lowest;
    logic [32:0]   r_highest, r_last_end, r_gap;

    t_result out_d;
    logic    out_v, out_rdy;
    t_result out_q;

    logic [5:0] vcount;
    always_comb begin
        vcount = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
            vcount = vcount + 6'(r_valid[k]);
        end
    end

    logic [IW-1:0] free_idx;
    logic          free_ok;
    always_comb begin
        free_idx = '0;
        free_ok  = 1'b0;
        for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
            if (!r_valid[k]) begin
                free_idx = IW'(k);
                free_ok  = 1'b1;
            end
        end
    end

    assign rd_addr = r_idx[IW-1:0];
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd <= mem[rd_addr];
    end

    logic [31:0] rd_key;
    logic rd_done;
    assign rd_key  = r_rd[MW-1 -: 32];
    assign rd_done = r_rd[0];

    logic [31:0] hb_key, hb_len;
    logic [COUNT_BITS-1:0] hb_pc, hb_sc;
    logic hb_done;
    assign {hb_key, hb_len, hb_pc, hb_sc, hb_done} = r_hit_data;

    logic [31:0] bb_key, bb_len;
    logic [COUNT_BITS-1:0] bb_pc, bb_sc;
    assign {bb_key, bb_len, bb_pc, bb_sc} = r_best_data[MW-1:1];
    logic [32:0] bb_end;
    assign bb_end = {1'b0, bb_key} + {1'b0, bb_len};

    // candidate for ordered searches
    logic cand;
    always_comb begin
        cand = r_rd_ok && r_valid[r_rd_idx];
        if (r_cmd == CMD_LOWEST) begin
            cand = cand && !rd_done;
        end else begin
            cand = cand && !r_seen[r_rd_idx];
        end
        cand = cand && (!r_best_ok || rd_key < bb_key);
    end

    logic [COUNT_BITS-1:0] cmax;
    assign cmax = '1;

    assign s_axis_tready = (r_state == S_IDLE);

    // write-back and single result
    logic [COUNT_BITS-1:0] n_pc, n_sc;
    logic [31:0] n_len;
    logic [32:0] n_end;
    always_comb begin
        n_pc  = hb_pc;
        n_sc  = hb_sc;
        n_len = hb_len;
        if (r_prim && hb_pc != cmax) n_pc = hb_pc + COUNT_BITS'(1);
        if (!r_prim && hb_sc != cmax) n_sc = hb_sc + COUNT_BITS'(1);
        if (r_cmd == CMD_SETLEN) n_len = r_len;
        n_end = {1'b0, hb_key} + {1'b0, n_len};
    end

    logic [32:0] gap_add, new_gap;
    logic [33:0] unused;
    always_comb begin
        gap_add = '0;
        if (!r_first && {1'b0, bb_key} > r_last_end) gap_add = {1'b0, bb_key} - r_last_end;
        new_gap = r_gap + gap_add;
        unused = {2'b0, r_lowest} + {1'b0, r_gap};
        if (r_last_end <= {1'b0, r_section})
            unused = unused + 34'({1'b0, r_section} - r_last_end);
    end

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_hit_idx;
        mem_wd = r_hit_data;
        out_v  = 1'b0;
        out_d  = '0;
        out_d.entry_total = vcount;
        out_d.last = 1'b1;
        unique case (r_state)
            S_WRITE: begin
                out_v = out_rdy;
                unique case (r_cmd)
                    CMD_ADD: begin
                        out_d.key_out = r_off;
                        if (r_hit) begin
                            mem_we = out_rdy;
                            mem_wd = {hb_key, hb_len, n_pc, n_sc, hb_done};
                            out_d.status = ST_FOUND;
                            out_d.region_end = n_end;
                        end else if (free_ok) begin
                            mem_we = out_rdy;
                            mem_wa = free_idx;
                            mem_wd = {r_off, 32'd0, COUNT_BITS'(r_prim),
                                      COUNT_BITS'(!r_prim), 1'b0};
                            out_d.status = ST_NEW;
                            out_d.region_end = {1'b0, r_off};
                            out_d.entry_total = vcount + 6'd1;
                        end else begin
                            out_d.status = ST_FULL;
                        end
                    end
                    CMD_SETLEN, CMD_DONE: begin
                        out_d.key_out = r_off;
                        if (r_hit) begin
                            mem_we = out_rdy;
                            mem_wd = {hb_key, n_len, hb_pc, hb_sc,
                                      hb_done | (r_cmd == CMD_DONE)};
                            out_d.status = ST_FOUND;
                            out_d.region_end = n_end;
                        end else begin
                            out_d.status = ST_NONE;
                        end
                    end
                    CMD_LOWEST: begin
                        if (r_best_ok) begin
                            out_d.status = ST_FOUND;
                            out_d.key_out = bb_key;
                            out_d.region_end = bb_end;
                        end else begin
                            out_d.status = ST_NONE;
                        end
                    end
                    default: begin
                        out_d.status = ST_NONE;
                        out_d.entry_total = '0;
                    end
                endcase
            end
            S_EMIT: begin
                out_v = out_rdy;
                out_d.status = ST_RECORD;
                out_d.last = 1'b0;
                out_d.key_out = bb_key;
                out_d.region_end = bb_end;
                out_d.many_primary = bb_pc > COUNT_BITS'(1);
                out_d.mixed_refs = !r_newer && bb_pc != '0 && bb_sc != '0;
                if (!r_first) begin
                    out_d.prior_end = r_last_end;
                    out_d.overlaps = {1'b0, bb_key} < r_last_end;
                end
            end
            S_SUMMARY: begin
                out_v = out_rdy;
                if (r_first) begin
                    out_d.status = ST_NONE;
                end else begin
                    out_d.status = ST_SUMMARY;
                    out_d.key_out = r_lowest;
                    out_d.region_end = r_highest;
                    out_d.past_section = r_last_end > {1'b0, r_section};
                    out_d.inner_gap = r_gap;
                    out_d.unused_total = unused;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_newer <= 1'b0;
            r_section <= '0;
            r_valid <= '0;
            r_idx <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'(CFG_NEWER)) r_newer <= i_cfg_data[0];
                else r_section <= i_cfg_data;
            end
            r_rd_ok  <= (r_state == S_SCAN) && (r_idx < EW'(TABLE_ENTRIES));
            r_rd_idx <= rd_addr;
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd  <= s_axis_tdata[2:0];
                        r_off  <= s_axis_tdata[34:3];
                        r_len  <= s_axis_tdata[66:35];
                        r_prim <= s_axis_tdata[67];
                        r_idx  <= '0;
                        r_hit  <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_seen <= '0;
                        r_first <= 1'b1;
                        r_gap <= '0;
                        r_highest <= '0;
                        r_last_end <= '0;
                        r_lowest <= '0;
                        if (s_axis_tdata[2:0] == CMD_CLEAR) begin
                            r_valid <= '0;
                            r_state <= S_WRITE;
                        end else if (s_axis_tdata[2:0] <= CMD_AUDIT) begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx < EW'(TABLE_ENTRIES)) r_idx <= r_idx + EW'(1);
                    if (r_rd_ok && r_valid[r_rd_idx] && rd_key == r_off) begin
                        r_hit <= 1'b1;
                        r_hit_idx <= r_rd_idx;
                        r_hit_data <= r_rd;
                    end
                    if (cand) begin
                        r_best_ok <= 1'b1;
                        r_best_idx <= r_rd_idx;
                        r_best_data <= r_rd;
                    end
                    if (r_idx == EW'(TABLE_ENTRIES) && !r_rd_ok) begin
                        if (r_cmd == CMD_AUDIT)
                            r_state <= (r_best_ok || cand) ? S_EMIT : S_SUMMARY;
                        else
                            r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (out_rdy) begin
                        if (r_cmd == CMD_ADD && !r_hit && free_ok)
                            r_valid[free_idx] <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (out_rdy) begin
                        r_seen[r_best_idx] <= 1'b1;
                        if (r_first) r_lowest <= bb_key;
                        r_gap <= new_gap;
                        if (bb_end > r_highest) r_highest <= bb_end;
                        r_last_end <= bb_end;
                        r_first <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_idx <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SUMMARY: begin
                    if (out_rdy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    rrta_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (out_v),
        .o_ready (out_rdy),
        .i_data  (out_d),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_q)
    );

    assign m_axis_tlast = out_q.last;
    assign m_axis_tdata = {6'd0, out_q.entry_total, out_q.unused_total,
                           out_q.inner_gap, out_q.past_section, out_q.overlaps,
                           out_q.mixed_refs, out_q.many_primary, out_q.prior_end,
                           out_q.region_end, out_q.key_out, out_q.status};

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("request taken while busy");
    a_write_only_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_WRITE))
        else $error("memory write outside write-back");
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUMMARY && out_v) |-> out_d.last)
        else $error("summary without last");
endmodule
`default_nettype wire
